/* rtl/block_occupancy_grid_core_defines.svh */
// Assertion shorthands for the occupancy grid checker.
// Every macro samples on the rising edge of clk.
`ifndef BLOCK_OCCUPANCY_GRID_CORE_DEFINES_SVH
`define BLOCK_OCCUPANCY_GRID_CORE_DEFINES_SVH

// Implication that is ignored while reset is asserted.
`define BOG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication that spans into the next cycle, ignored while reset is asserted.
`define BOG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Property that is checked at every edge, during reset too.
`define BOG_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) (expr)) \
		else $error(msg);

`endif

/* rtl/bog_pkg.sv */
package bog_pkg;

	localparam int PIX_W     = 8;
	localparam int IDX_W     = 20;
	localparam int SLOT_W    = 12;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int BLK_RAW_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam int RESET_BLOCK = 8;
	localparam int RESET_DIM   = 800;

	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	// one classified pixel, front to back
	typedef struct packed {
		logic              black;
		logic              first_col;
		logic              first_row;
		logic              col_done;
		logic              row_done;
		logic              last;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  index;
	} cmd_t;

	// one finished cell
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             occupied;
		logic             last;
	} res_t;

endpackage

/* rtl/bog_fifo.sv */
module bog_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/bog_front.sv */
module bog_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_BLOCK  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bog_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bog_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_fire,
	input  logic [bog_pkg::PIX_W-1:0]        pixel_red,
	output bog_pkg::cmd_t                    cmd
);
	import bog_pkg::*;

	localparam int BW  = $clog2(MAX_BLOCK + 1);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int BIW = $clog2(MAX_BLOCK);

	localparam int BLK_RST = (RESET_BLOCK > MAX_BLOCK)  ? MAX_BLOCK  : RESET_BLOCK;
	localparam int WID_RST = (RESET_DIM   > MAX_WIDTH)  ? MAX_WIDTH  : RESET_DIM;
	localparam int HGT_RST = (RESET_DIM   > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

	logic [BW-1:0]        blk_q;
	logic [WW-1:0]        wid_q;
	logic [HW-1:0]        hgt_q;
	logic [CW-1:0]        pcol_q;
	logic [RW-1:0]        prow_q;
	logic [BIW-1:0]       cib_q;
	logic [BIW-1:0]       rib_q;
	logic [CW-1:0]        ccol_q;
	logic [IDX_W-1:0]     base_q;

	logic [BLK_RAW_W-1:0] blk_raw;
	logic [BW-1:0]        blk_new;
	logic [WW-1:0]        wid_new;
	logic [HW-1:0]        hgt_new;
	logic                 cfg_hit;
	logic                 end_col;
	logic                 end_row;
	logic                 col_full;
	logic                 row_full;

	// saturate register writes into their legal range
	always_comb begin
		blk_raw = cfg_data[BLK_RAW_W-1:0];
		if (blk_raw == '0) begin
			blk_new = BW'(1);
		end else if (int'(blk_raw) > MAX_BLOCK) begin
			blk_new = BW'(MAX_BLOCK);
		end else begin
			blk_new = BW'(blk_raw);
		end
		if (cfg_data == '0) begin
			wid_new = WW'(1);
			hgt_new = HW'(1);
		end else begin
			wid_new = (int'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
			hgt_new = (int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_IMAGE_WIDTH
		|| cfg_index == REG_IMAGE_HEIGHT);

	assign end_col  = (WW'(pcol_q) + WW'(1)) == wid_q;
	assign end_row  = (HW'(prow_q) + HW'(1)) == hgt_q;
	assign col_full = (BW'(cib_q) + BW'(1)) == blk_q;
	assign row_full = (BW'(rib_q) + BW'(1)) == blk_q;

	always_comb begin
		cmd.black     = (pixel_red == '0);
		cmd.first_col = (cib_q == '0);
		cmd.first_row = (rib_q == '0);
		cmd.col_done  = col_full || end_col;
		cmd.row_done  = row_full || end_row;
		cmd.last      = end_col && end_row;
		cmd.slot      = SLOT_W'(ccol_q);
		cmd.index     = base_q + IDX_W'(ccol_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q  <= BW'(BLK_RST);
			wid_q  <= WW'(WID_RST);
			hgt_q  <= HW'(HGT_RST);
			pcol_q <= '0;
			prow_q <= '0;
			cib_q  <= '0;
			rib_q  <= '0;
			ccol_q <= '0;
			base_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_BLOCK_SIZE:   blk_q <= blk_new;
				REG_IMAGE_WIDTH:  wid_q <= wid_new;
				REG_IMAGE_HEIGHT: hgt_q <= hgt_new;
				default:          blk_q <= blk_q;
			endcase
			// drop the image in progress
			pcol_q <= '0;
			prow_q <= '0;
			cib_q  <= '0;
			rib_q  <= '0;
			ccol_q <= '0;
			base_q <= '0;
		end else if (in_fire) begin
			if (end_col) begin
				pcol_q <= '0;
				cib_q  <= '0;
				ccol_q <= '0;
				if (end_row) begin
					prow_q <= '0;
					rib_q  <= '0;
					base_q <= '0;
				end else begin
					prow_q <= prow_q + 1'b1;
					if (row_full) begin
						rib_q  <= '0;
						// cells in a row = last cell column + 1
						base_q <= base_q + IDX_W'(ccol_q) + IDX_W'(1);
					end else begin
						rib_q <= rib_q + 1'b1;
					end
				end
			end else begin
				pcol_q <= pcol_q + 1'b1;
				if (col_full) begin
					cib_q  <= '0;
					ccol_q <= ccol_q + 1'b1;
				end else begin
					cib_q <= cib_q + 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/bog_back.sv */
module bog_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bog_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output bog_pkg::res_t res
);
	import bog_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic          flag_mem [MAX_WIDTH];
	logic          b_vld_s1;
	cmd_t          b_cmd_s1;
	logic          rd_flag_s1;
	logic          byp_hit_s1;
	logic          byp_val_s1;
	logic          acc_q;

	logic          emit;
	logic          b_adv;
	logic          load;
	logic          prev_flag;
	logic          new_flag;
	logic          wr_en;

	assign emit    = b_cmd_s1.col_done && b_cmd_s1.row_done;
	assign b_adv   = b_vld_s1 && !(emit && res_full);
	assign load    = cmd_valid && (!b_vld_s1 || b_adv);
	assign cmd_pop = load;

	// Inside a cell row segment carry the running mark; at a segment start take
	// the stored mark, or nothing on the first pixel row of the cell.
	always_comb begin
		if (!b_cmd_s1.first_col) begin
			prev_flag = acc_q;
		end else if (b_cmd_s1.first_row) begin
			prev_flag = 1'b0;
		end else begin
			prev_flag = byp_hit_s1 ? byp_val_s1 : rd_flag_s1;
		end
		new_flag = prev_flag || b_cmd_s1.black;
	end

	assign wr_en     = b_adv && b_cmd_s1.col_done && !b_cmd_s1.row_done;
	assign res_push  = b_adv && emit;
	assign res.index = b_cmd_s1.index;
	assign res.occupied = new_flag;
	assign res.last  = b_cmd_s1.last;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flag_mem[b_cmd_s1.slot[AW-1:0]] <= new_flag;
		end
		if (load) begin
			rd_flag_s1 <= flag_mem[cmd.slot[AW-1:0]];
			// same-edge write is missed by the read; forward it
			byp_hit_s1 <= wr_en && (b_cmd_s1.slot == cmd.slot);
			byp_val_s1 <= new_flag;
			b_cmd_s1   <= cmd;
		end
		if (b_adv) begin
			acc_q <= new_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_s1 <= 1'b0;
		end else if (load) begin
			b_vld_s1 <= 1'b1;
		end else if (b_adv) begin
			b_vld_s1 <= 1'b0;
		end
	end

endmodule

/* rtl/block_occupancy_grid_core.sv */
// Block occupancy grid: marks each square cell of an image occupied when any
// of its pixels has a red value of zero.
// Input queue: drive pixel_red with push; a transfer happens on a clock edge
// with push high and full low. Pixels come in raster order, one per transfer.
// Result queue: while empty is low the oldest finished cell sits on
// cell_index / occupied / last_cell; pop high with empty low transfers it.
// A cell is finished on its last existing pixel (edge cells may be cut short)
// and last_cell flags the final cell of the image; the next pixel starts a
// new image.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 block
// size, 1 image width, 2 image height), saturated to 1..max. A write restarts
// the image; writes to other indexes are ignored. Write only while idle.
// Result path: command queue, back-end stage register, result queue.
// Throughput: one pixel per cycle, set by the flag memory read-modify-write
// in the back end (one read and one write a cycle), forwarding a same-edge write.
// Stalls: a held result backs up the result queue, then the back end, then the
// command queue between front and back; full rises only when that is full.
// Reset: queues empty, counters cleared, registers at 8 / 800 / 800 (or the
// maximum). The flag memory is not cleared: the first pixel of every cell
// overrides whatever its column slot held.
module block_occupancy_grid_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_BLOCK  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bog_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bog_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [bog_pkg::PIX_W-1:0]     pixel_red,
	output logic                          empty,
	input  logic                          pop,
	output logic [bog_pkg::IDX_W-1:0]     cell_index,
	output logic                          occupied,
	output logic                          last_cell
);
	import bog_pkg::*;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	logic       in_fire;
	cmd_t       front_cmd;
	cmd_t       head_cmd;
	logic       cmd_empty;
	logic       cmd_pop;
	logic       res_push;
	logic       res_full;
	res_t       back_res;
	res_t       out_res;

	// take a pixel whenever the command queue has room
	assign in_fire = push && !full;

	// front: count positions, classify each pixel
	bog_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BLOCK  (MAX_BLOCK)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.pixel_red (pixel_red),
		.cmd       (front_cmd)
	);

	// decouple front from back
	bog_fifo #(
		.W     (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.wdata  (front_cmd),
		.pop    (cmd_pop),
		.rdata  (head_cmd),
		.full   (full),
		.empty  (cmd_empty)
	);

	// back: flag read-modify-write, emit finished cells
	bog_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// hold finished cells until the consumer pops them
	bog_fifo #(
		.W     (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.pop    (pop),
		.rdata  (out_res),
		.full   (res_full),
		.empty  (empty)
	);

	assign cell_index = out_res.index;
	assign occupied   = out_res.occupied;
	assign last_cell  = out_res.last;

endmodule

/* rtl/bog_chk.sv */
`include "block_occupancy_grid_core_defines.svh"

module bog_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bog_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bog_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          push,
	input  logic                          full,
	input  logic [bog_pkg::PIX_W-1:0]     pixel_red,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [bog_pkg::IDX_W-1:0]     cell_index,
	input  logic                          occupied,
	input  logic                          last_cell
);
	import bog_pkg::*;

	logic [IDX_W-1:0] exp_idx_q;
	logic             out_xfer;
	logic             restart;
	logic [IDX_W+1:0] out_word;

	assign out_xfer = pop && !empty;
	assign restart  = cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_IMAGE_WIDTH
		|| cfg_index == REG_IMAGE_HEIGHT);
	assign out_word = {cell_index, occupied, last_cell};

	// cells leave in row-major order; a new image or a restart begins at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (restart) begin
			exp_idx_q <= '0;
		end else if (out_xfer) begin
			exp_idx_q <= last_cell ? '0 : cell_index + 1'b1;
		end
	end

	`BOG_ASSERT_ALWAYS(a_reset_idle, arst_n || (empty && !full), "queues not idle in reset")
	`BOG_ASSERT_IMP(a_cell_order, out_xfer, cell_index == exp_idx_q, "cell out of order")
	`BOG_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(out_word), "result moved")

	logic unused_ok;
	assign unused_ok = ^{cfg_data, push, pixel_red};

endmodule

bind block_occupancy_grid_core bog_chk u_bog_chk (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Testbench for block_occupancy_grid_core.
module testbench;
	import bog_pkg::*;

	localparam int GRID_MAX_W   = 1024;
	localparam int GRID_MAX_H   = 1024;
	localparam int GRID_MAX_BLK = 64;

	// index past the last register: the block must ignore the write
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int PIXEL_TARGET   = 950;
	localparam int DRAIN_CYCLES   = 10;     // result path through both queues and the back end, plus queue slack
	localparam int TAIL_CYCLES    = 20;
	localparam int BACKLOG_CYCLES = 200;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int WIDE_ROW_PHASE = 3;
	localparam int PRINT_CAP      = 100;

	typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL} row_kind_e;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_CELL} row_check_e;
	typedef enum logic [2:0] {
		SHAPE_NORMAL, SHAPE_TINY, SHAPE_WIDE, SHAPE_TALL, SHAPE_WIDE_ROW
	} shape_e;

	typedef struct {
		row_kind_e             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]      data;
		logic [PIX_W-1:0]      red;
		row_check_e            check;
		res_t                  want_res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 push;
	logic                 full;
	logic [PIX_W-1:0]     pixel_red;
	logic                 empty;
	logic                 pop;
	logic [IDX_W-1:0]     cell_index;
	logic                 occupied;
	logic                 last_cell;

	// Shadow of the block: configuration and raster position of the next pixel
	logic [6:0]       cell_size;
	logic [10:0]      img_w;
	logic [10:0]      img_h;
	logic [9:0]       pix_col;
	logic [9:0]       pix_row;
	logic [9:0]       cell_col;
	logic [5:0]       col_in_cell;
	logic [5:0]       row_in_cell;
	logic [IDX_W-1:0] row_base;
	bit               occ_flags [GRID_MAX_W];

	res_t      pending_cells[$];
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	int        pixels_sent    = 0;
	int        cycle_count    = 0;
	bit        backlog_req    = 1'b0;
	bit        backlog_hold   = 1'b0;

	block_occupancy_grid_core #(
		.MAX_WIDTH (GRID_MAX_W),
		.MAX_HEIGHT(GRID_MAX_H),
		.MAX_BLOCK (GRID_MAX_BLK)
	) dut (.*);

	// Saturate a register value into 1..hi, the way the block does on a write.
	function automatic logic [10:0] clamp_reg(input logic [10:0] v, input int hi);
		if (v == 11'd0)
			return 11'd1;
		if (int'(v) > hi)
			return 11'(hi);
		return v;
	endfunction

	function automatic void restart_image();
		pix_col     = '0;
		pix_row     = '0;
		cell_col    = '0;
		col_in_cell = '0;
		row_in_cell = '0;
		row_base    = '0;
		foreach (occ_flags[i])
			occ_flags[i] = 1'b0;
	endfunction

	function automatic void grid_reset();
		cell_size = 7'(RESET_BLOCK);
		img_w     = 11'(RESET_DIM);
		img_h     = 11'(RESET_DIM);
		restart_image();
	endfunction

	// Mirror a register write; any known register restarts the image.
	function automatic void grid_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_BLOCK_SIZE:   cell_size = 7'(clamp_reg({4'd0, data[6:0]}, GRID_MAX_BLK));
			REG_IMAGE_WIDTH:  img_w = clamp_reg(data, GRID_MAX_W);
			REG_IMAGE_HEIGHT: img_h = clamp_reg(data, GRID_MAX_H);
			default:          return;
		endcase
		restart_image();
	endfunction

	// Take one pixel in raster order; return 1 with the finished cell when the
	// pixel is the last existing one of its cell.
	function automatic bit grid_step(input logic [PIX_W-1:0] red, output res_t fin);
		int cols;
		bit end_col;
		bit end_row;
		bit col_done;
		bit row_done;
		bit done;
		cols     = (int'(img_w) + int'(cell_size) - 1) / int'(cell_size);
		end_col  = int'(pix_col) + 1 >= int'(img_w);
		end_row  = int'(pix_row) + 1 >= int'(img_h);
		col_done = int'(col_in_cell) + 1 >= int'(cell_size) || end_col;
		row_done = int'(row_in_cell) + 1 >= int'(cell_size) || end_row;
		done     = col_done && row_done;
		fin      = '0;

		if (red == '0)
			occ_flags[cell_col] = 1'b1;

		// finish the cell and free its column flag for the next cell row
		if (done) begin
			fin.index           = row_base + IDX_W'(cell_col);
			fin.occupied        = occ_flags[cell_col];
			fin.last            = end_col && end_row;
			occ_flags[cell_col] = 1'b0;
		end

		// advance the raster position
		if (end_col) begin
			pix_col     = '0;
			col_in_cell = '0;
			cell_col    = '0;
			if (end_row) begin
				pix_row     = '0;
				row_in_cell = '0;
				row_base    = '0;
			end else begin
				pix_row = pix_row + 10'd1;
				if (int'(row_in_cell) + 1 >= int'(cell_size)) begin
					row_in_cell = '0;
					row_base    = row_base + IDX_W'(cols);
				end else begin
					row_in_cell = row_in_cell + 6'd1;
				end
			end
		end else begin
			pix_col = pix_col + 10'd1;
			if (int'(col_in_cell) + 1 >= int'(cell_size)) begin
				col_in_cell = '0;
				cell_col    = cell_col + 10'd1;
			end else begin
				col_in_cell = col_in_cell + 6'd1;
			end
		end
		return done;
	endfunction

	// Black with probability 1/odds, otherwise any non-black value.
	function automatic logic [PIX_W-1:0] draw_red(input int odds);
		if ($urandom_range(1, odds) == 1)
			return '0;
		return PIX_W'($urandom_range(1, 255));
	endfunction

	function automatic void dir_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		stim_row_t r;
		r.kind     = ROW_WRITE;
		r.reg_idx  = idx;
		r.data     = data;
		r.red      = '0;
		r.check    = CHK_NONE;
		r.want_res = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void dir_pixel(input logic [PIX_W-1:0] red, input row_check_e check,
			input int index, input bit occ, input bit lst);
		stim_row_t r;
		r.kind              = ROW_PIXEL;
		r.reg_idx           = REG_BLOCK_SIZE;
		r.data              = '0;
		r.red               = red;
		r.check             = check;
		r.want_res.index    = IDX_W'(index);
		r.want_res.occupied = occ;
		r.want_res.last     = lst;
		directed_rows.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// Offer one pixel after a random gap and hold it until the transfer.
	// Typed rows queue their own expectation; the shadow still advances.
	task automatic send_pixel(input logic [PIX_W-1:0] red, input bit eager,
			input row_check_e check, input res_t typed);
		int   gap;
		bit   has_cell;
		res_t fin;
		gap = (eager || backlog_req || backlog_hold) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push      <= 1'b1;
		pixel_red <= red;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pixels_sent++;
		has_cell = grid_step(red, fin);
		if (check == CHK_CELL)
			pending_cells.push_back(typed);
		else if (check == CHK_MODEL && has_cell)
			pending_cells.push_back(fin);
	endtask

	// Stop offering, wait for every pending cell, then let the pipeline empty:
	// pixels that finish no cell may still be in flight.
	task automatic settle();
		@(negedge clk) push <= 1'b0;
		while (pending_cells.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk) cfg_we <= 1'b0;
		grid_config(idx, data);
	endtask

	initial begin : clock_gen
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drive every input to a known value at time zero, then release reset.
	initial begin : reset_gen
		arst_n    <= 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_BLOCK_SIZE;
		cfg_data  = '0;
		push      = 1'b0;
		pixel_red = '0;
		pop       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// Hard stop: the slowest legal run is far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		shape_e    shape;
		int        phase;
		int        pick;
		int        total;
		int        count;
		int        probe_at;
		int        odds;
		bit        eager;
		logic [6:0] blk_raw;

		grid_reset();

		// Reset geometry is 800 x 800 with 8-pixel cells: the first pixels finish nothing.
		dir_pixel(8'd0,   CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_NONE, 0, 1'b0, 1'b0);
		// Zero cell size saturates to one; a 2 x 1 image gives one cell per pixel.
		dir_write(REG_BLOCK_SIZE,   11'd0);
		dir_write(REG_IMAGE_WIDTH,  11'd2);
		dir_write(REG_IMAGE_HEIGHT, 11'd0);
		dir_pixel(8'd0,   CHK_CELL, 0, 1'b1, 1'b0);
		// A write past the register list must not restart the image.
		dir_write(REG_UNUSED, 11'h5A5);
		dir_pixel(8'd255, CHK_CELL, 1, 1'b0, 1'b1);
		// Only the low 7 bits of the cell size count: 0x0C0 reads as 64.
		// A 3 x 2 image is then one cut-short cell, finished on its last pixel.
		dir_write(REG_BLOCK_SIZE,   11'h0C0);
		dir_write(REG_IMAGE_WIDTH,  11'd3);
		dir_write(REG_IMAGE_HEIGHT, 11'd2);
		dir_pixel(8'd255, CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd1,   CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd128, CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd254, CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd127, CHK_NONE, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_CELL, 0, 1'b0, 1'b1);
		// 0x080 masks to zero -> size 1; width 0 -> 1; height saturates to 1024.
		dir_write(REG_BLOCK_SIZE,   11'h080);
		dir_write(REG_IMAGE_WIDTH,  11'd0);
		dir_write(REG_IMAGE_HEIGHT, 11'h7FF);
		dir_pixel(8'd0,   CHK_CELL, 0, 1'b1, 1'b0);
		dir_pixel(8'd255, CHK_CELL, 1, 1'b0, 1'b0);
		dir_pixel(8'd0,   CHK_CELL, 2, 1'b1, 1'b0);
		// Cut-short cells at both the right and the bottom edge.
		dir_write(REG_BLOCK_SIZE,   11'd2);
		dir_write(REG_IMAGE_WIDTH,  11'd3);
		dir_write(REG_IMAGE_HEIGHT, 11'd3);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd0,   CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd0,   CHK_MODEL, 0, 1'b0, 1'b0);
		dir_pixel(8'd255, CHK_MODEL, 0, 1'b0, 1'b0);

		wait (arst_n === 1'b1);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.reg_idx, row.data);
			end else begin
				send_pixel(row.red, 1'b0, row.check, row.want_res);
			end
		end

		// Random phases: reconfigure while idle, then stream whole images.
		// Some images are abandoned halfway, and the huge ones always are.
		phase = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			phase++;
			settle();
			eager = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0:       odds = 2;
				1:       odds = 16;
				default: odds = 256;
			endcase

			pick = $urandom_range(0, 11);
			if (phase == WIDE_ROW_PHASE)
				shape = SHAPE_WIDE_ROW;
			else if (pick == 0)
				shape = SHAPE_WIDE;
			else if (pick == 1)
				shape = SHAPE_TALL;
			else if (pick == 2)
				shape = SHAPE_TINY;
			else
				shape = SHAPE_NORMAL;

			case (shape)
				SHAPE_WIDE_ROW: begin
					// a long stretch of a 1024-pixel row of 1-pixel cells;
					// the receiver holds off meanwhile so the block backs up
					write_reg(REG_BLOCK_SIZE,   {4'($urandom), 7'd1});
					write_reg(REG_IMAGE_WIDTH,  11'h7FF);
					write_reg(REG_IMAGE_HEIGHT, 11'd1);
					backlog_req = 1'b1;
				end
				SHAPE_WIDE: begin
					write_reg(REG_BLOCK_SIZE,   11'($urandom));
					write_reg(REG_IMAGE_WIDTH,  11'($urandom_range(1024, 2047)));
					write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(0, 1)));
				end
				SHAPE_TALL: begin
					write_reg(REG_BLOCK_SIZE,   {4'($urandom), 7'($urandom_range(64, 127))});
					write_reg(REG_IMAGE_WIDTH,  11'($urandom_range(1, 3)));
					write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(1024, 2047)));
				end
				SHAPE_TINY: begin
					write_reg(REG_BLOCK_SIZE,   {4'($urandom), 7'd0});
					write_reg(REG_IMAGE_WIDTH,  11'd0);
					write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(0, 3)));
				end
				default: begin
					// keep the old cell size now and then
					if ($urandom_range(0, 3) != 0) begin
						if ($urandom_range(0, 9) == 0)
							blk_raw = 7'($urandom_range(0, 127));
						else
							blk_raw = 7'($urandom_range(1, 9));
						write_reg(REG_BLOCK_SIZE, {4'($urandom), blk_raw});
					end
					write_reg(REG_IMAGE_WIDTH,  11'($urandom_range(0, 24)));
					write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(0, 12)));
				end
			endcase

			total = int'(img_w) * int'(img_h);
			if (shape == SHAPE_WIDE || shape == SHAPE_TALL)
				count = $urandom_range(20, 150);
			else if (shape == SHAPE_WIDE_ROW)
				count = $urandom_range(200, 300);
			else if (total > 1 && $urandom_range(0, 5) == 0)
				count = $urandom_range(1, total - 1);
			else
				count = total * $urandom_range(1, (total <= 64) ? 3 : 1);

			// keep the run near its item budget
			if (count > PIXEL_TARGET - pixels_sent)
				count = PIXEL_TARGET - pixels_sent;

			// now and then pause mid-image for a write to the unused index
			probe_at = -1;
			if (count > 1 && $urandom_range(0, 3) == 0)
				probe_at = $urandom_range(1, count - 1);

			for (int k = 0; k < count; k++) begin
				if (k == probe_at) begin
					settle();
					write_reg(REG_UNUSED, 11'($urandom));
				end
				send_pixel(draw_red(odds), eager, CHK_MODEL, '0);
			end
		end

		// Drain: wait for every pending cell, then watch for strays.
		@(negedge clk) push <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: pop after a random gap, with zero-gap runs and one long hold-off
	// on request; compare each transfer with the oldest pending cell.
	initial begin : result_drain
		int   gap;
		int   held;
		int   rush_left;
		res_t want;
		rush_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (backlog_req) begin
				backlog_req  = 1'b0;
				backlog_hold = 1'b1;
				@(negedge clk) pop <= 1'b0;
				for (held = 1; held < BACKLOG_CYCLES; held++)
					@(negedge clk);
				backlog_hold = 1'b0;
			end else begin
				if (rush_left > 0) begin
					gap = 0;
					rush_left--;
				end else if ($urandom_range(0, 15) == 0) begin
					gap       = 0;
					rush_left = $urandom_range(10, 40);
				end else begin
					gap = $urandom_range(0, 8);
				end
				if (gap > 0) begin
					@(negedge clk) pop <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
			@(negedge clk) pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);

			if (pending_cells.size() == 0) begin
				report_mismatch("cell_index of a cell nobody expected", int'(cell_index), -1);
			end else begin
				want = pending_cells.pop_front();
				if (cell_index !== want.index)
					report_mismatch("cell_index", int'(cell_index), int'(want.index));
				if (occupied !== want.occupied)
					report_mismatch("occupied", int'(occupied), int'(want.occupied));
				if (last_cell !== want.last)
					report_mismatch("last_cell", int'(last_cell), int'(want.last));
			end
		end
	end

endmodule
